[rtl/ntp_dod_pkg.sv]
// Shared types and constants for the time-exchange delay, offset and dispersion unit.
package ntp_dod_pkg;

    localparam int STAMP_W = 64;
    localparam int SLOT_W = 3;
    localparam int SECONDS_W = 32;
    localparam int ROOT_DISP_IN_W = 32;
    localparam int ROOT_DISP_OUT_W = 48;
    localparam int FRAC_W = 32;

    localparam logic [SECONDS_W-1:0] EPOCH_RESET = 32'd2208988800;

    typedef struct packed {
        logic [SLOT_W-1:0]         slot;
        logic [STAMP_W-1:0]        client_send_time;
        logic [STAMP_W-1:0]        server_receive_time;
        logic [STAMP_W-1:0]        server_transmit_time;
        logic [STAMP_W-1:0]        client_receive_time;
        logic [ROOT_DISP_IN_W-1:0] server_root_disp;
    } req_item_t;

    typedef struct packed {
        logic signed [STAMP_W-1:0]  round_trip_delay;
        logic signed [STAMP_W-1:0]  clock_offset;
        logic [STAMP_W-1:0]         delay_dispersion;
        logic [ROOT_DISP_OUT_W-1:0] root_disp_wide;
    } rsp_item_t;

    // Delay, offset and widened root dispersion of one exchange.
    typedef struct packed {
        logic [STAMP_W-1:0]         delay;
        logic [STAMP_W-1:0]         offset;
        logic [ROOT_DISP_OUT_W-1:0] root_disp;
    } calc_res_t;

    // Extremes of the delay window.
    typedef struct packed {
        logic               have_min;
        logic [STAMP_W-1:0] max_delay;
        logic [STAMP_W-1:0] min_delay;
    } win_stats_t;

endpackage

[rtl/ntp_dod_calc.sv]
// Delay and offset arithmetic for one exchange: epoch correction, differences and halving.
module ntp_dod_calc
    import ntp_dod_pkg::*;
(
    input  req_item_t              item,
    input  logic [SECONDS_W-1:0]   epoch_offset_seconds,
    output calc_res_t              res
);

    logic [STAMP_W-1:0] epoch_shift;
    logic [STAMP_W-1:0] t2_adj;
    logic [STAMP_W-1:0] t3_adj;
    logic [STAMP_W-1:0] d41;
    logic [STAMP_W-1:0] d23;
    logic [STAMP_W-1:0] d21;
    logic [STAMP_W-1:0] d34;
    logic [STAMP_W:0]   delay_sum;
    logic [STAMP_W:0]   offset_sum;

    always_comb
    begin
        epoch_shift = {epoch_offset_seconds, {FRAC_W{1'b0}}};
        t2_adj = item.server_receive_time - epoch_shift;
        t3_adj = item.server_transmit_time - epoch_shift;
        d41 = item.client_receive_time - item.client_send_time;
        d23 = t2_adj - t3_adj;
        d21 = t2_adj - item.client_send_time;
        d34 = t3_adj - item.client_receive_time;
        // Sign-extended sums are exact, so dropping the low bit is a floor halving.
        delay_sum = {d41[STAMP_W-1], d41} + {d23[STAMP_W-1], d23};
        offset_sum = {d21[STAMP_W-1], d21} + {d34[STAMP_W-1], d34};
        res.delay = delay_sum[STAMP_W:1];
        res.offset = offset_sum[STAMP_W:1];
        res.root_disp = {item.server_root_disp, 16'h0000};
    end

endmodule

[rtl/ntp_dod_window.sv]
// Delay window storage with registered maximum and nonzero minimum.
module ntp_dod_window
    import ntp_dod_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [SLOT_W-1:0]  wr_slot,
    input  logic [STAMP_W-1:0] wr_delay,
    input  logic               stats_en,
    output win_stats_t         stats
);

    localparam int IDX_W = $clog2(WINDOW_DEPTH);

    logic [STAMP_W-1:0] window_reg [WINDOW_DEPTH];
    logic [SLOT_W-1:0]  slot_wrapped;
    logic [IDX_W-1:0]   wr_idx;
    win_stats_t         stats_reg;
    win_stats_t         stats_next;

    // The slot is taken modulo the window depth by repeated compare and subtract.
    always_comb
    begin
        slot_wrapped = wr_slot;
        for (int k = 0; k < (1 << SLOT_W); k++)
        begin
            if (int'(slot_wrapped) >= WINDOW_DEPTH)
            begin
                slot_wrapped = slot_wrapped - SLOT_W'(WINDOW_DEPTH);
            end
        end
    end

    assign wr_idx = IDX_W'(slot_wrapped);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            window_reg[wr_idx] <= wr_delay;
        end
    end

    // Zero entries count as empty for the minimum but still take part in the maximum.
    always_comb
    begin
        stats_next.max_delay = window_reg[0];
        stats_next.min_delay = '0;
        stats_next.have_min = 1'b0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if ($signed(stats_next.max_delay) < $signed(window_reg[i]))
            begin
                stats_next.max_delay = window_reg[i];
            end
            if ((window_reg[i] != '0) && (!stats_next.have_min ||
                ($signed(window_reg[i]) < $signed(stats_next.min_delay))))
            begin
                stats_next.min_delay = window_reg[i];
                stats_next.have_min = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stats_en)
        begin
            stats_reg <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule

[rtl/ntp_delay_offset_dispersion.sv]
// Top level of the time-exchange delay, offset and dispersion unit.
// Each item passes through four registers (input, arithmetic, window statistics, output), and one
// item can be taken every cycle unless a result-side stall has filled the stages. An item's delay
// is written into the window as it leaves the input register, and the window spread it reports
// is captured as it leaves the arithmetic register, so it always includes its own delay and
// no later one. A stall on the result side holds each stage up to the first empty one.
module ntp_delay_offset_dispersion
    import ntp_dod_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_item_t            req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_item_t            rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SECONDS_W-1:0] cfg_data
);

    logic [SECONDS_W-1:0] epoch_reg;
    logic                 s1_valid_reg;
    req_item_t            s1_reg;
    logic                 s2_valid_reg;
    calc_res_t            s2_reg;
    logic                 s3_valid_reg;
    calc_res_t            s3_reg;
    logic                 out_valid_reg;
    rsp_item_t            out_reg;

    logic                 ld1;
    logic                 ld2;
    logic                 ld3;
    logic                 ld_out;
    calc_res_t            calc_res;
    win_stats_t           stats;
    logic [STAMP_W-1:0]   spread;

    // A stage loads when it is empty or its content moves on at the same edge.
    assign ld_out = !out_valid_reg || rsp_ready;
    assign ld3 = !s3_valid_reg || ld_out;
    assign ld2 = !s2_valid_reg || ld3;
    assign ld1 = !s1_valid_reg || ld2;

    assign req_ready = ld1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= EPOCH_RESET;
        end
        else if (cfg_valid)
        begin
            epoch_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_valid_reg <= req_valid;
            end
            if (ld2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ld3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ld_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_reg <= req;
        end
        if (ld2)
        begin
            s2_reg <= calc_res;
        end
        if (ld3)
        begin
            s3_reg <= s2_reg;
        end
        if (ld_out)
        begin
            out_reg.round_trip_delay <= s3_reg.delay;
            out_reg.clock_offset <= s3_reg.offset;
            out_reg.delay_dispersion <= spread;
            out_reg.root_disp_wide <= s3_reg.root_disp;
        end
    end

    ntp_dod_calc u_calc
    (
        .item                 (s1_reg),
        .epoch_offset_seconds (epoch_reg),
        .res                  (calc_res)
    );

    ntp_dod_window
    #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    )
    u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (ld2 && s1_valid_reg),
        .wr_slot  (s1_reg.slot),
        .wr_delay (calc_res.delay),
        .stats_en (ld3),
        .stats    (stats)
    );

    assign spread = stats.have_min ? (stats.max_delay - stats.min_delay) : '0;

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

endmodule

[verif/tb_ntp_delay_offset_dispersion.sv]
// Self-checking testbench for the time-exchange delay, offset and dispersion unit.
`timescale 1ns / 100ps

module tb_ntp_delay_offset_dispersion
    import ntp_dod_pkg::*;
();

    localparam int WIN_DEPTH = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_ready;
    req_item_t req_item = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_item_t rsp_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SECONDS_W-1:0] cfg_data = '0;

    // Predictor state: epoch register and delay window.
    logic [SECONDS_W-1:0] epoch_secs = EPOCH_RESET;
    logic signed [STAMP_W-1:0] delay_win [WIN_DEPTH];

    req_item_t pending_exchanges[$];
    rsp_item_t expected_results[$];

    logic req_took = 1'b0;
    int idle_odds = 0;
    int send_gap = 0;
    int stall_gap = 0;
    int mismatch_count = 0;
    int cycles = 0;

    ntp_delay_offset_dispersion #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req_item),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sum of two signed 32.32 values taken in 65 bits, then halved towards minus infinity.
    function automatic logic [STAMP_W-1:0] halve_sum(input logic [STAMP_W-1:0] a,
                                                     input logic [STAMP_W-1:0] b);
        logic [STAMP_W:0] total;
        total = {a[STAMP_W-1], a} + {b[STAMP_W-1], b};
        return total[STAMP_W:1];
    endfunction

    function automatic rsp_item_t predict_exchange(input req_item_t it);
        logic [STAMP_W-1:0] shift;
        logic [STAMP_W-1:0] t2;
        logic [STAMP_W-1:0] t3;
        logic signed [STAMP_W-1:0] top;
        logic signed [STAMP_W-1:0] bottom;
        bit found;
        rsp_item_t r;
        int i;
        shift = {epoch_secs, 32'h0};
        t2 = it.server_receive_time - shift;
        t3 = it.server_transmit_time - shift;
        r.round_trip_delay = halve_sum(it.client_receive_time - it.client_send_time, t2 - t3);
        r.clock_offset = halve_sum(t2 - it.client_send_time, t3 - it.client_receive_time);
        delay_win[it.slot % WIN_DEPTH] = r.round_trip_delay;
        // Empty entries take part in the maximum but never in the minimum.
        top = delay_win[0];
        bottom = '0;
        found = 1'b0;
        for (i = 0; i < WIN_DEPTH; i++)
        begin
            if (delay_win[i] > top)
                top = delay_win[i];
            if (delay_win[i] != 0 && (!found || delay_win[i] < bottom))
            begin
                bottom = delay_win[i];
                found = 1'b1;
            end
        end
        r.delay_dispersion = found ? top - bottom : '0;
        r.root_disp_wide = {it.server_root_disp, 16'h0};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (mismatch_count < 10)
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
        mismatch_count++;
    endtask

    // Sender: one item at a time, held until accepted, with random idle bursts between items.
    always @(negedge clk)
    begin
        if (rst_n && !(req_valid && !req_took))
        begin
            if (send_gap == 0 && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
                send_gap = $urandom_range(1, 10);
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_exchanges.size() != 0)
            begin
                req_item <= pending_exchanges.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_gap == 0 && idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0)
                stall_gap = $urandom_range(1, 10);
            if (stall_gap > 0)
            begin
                stall_gap--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted item, check every accepted result.
    always @(posedge clk)
    begin
        rsp_item_t want;
        req_took <= req_valid && req_ready;
        if (rst_n && req_valid && req_ready)
            expected_results.push_back(predict_exchange(req_item));
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", '0, rsp_item.round_trip_delay);
            else
            begin
                want = expected_results.pop_front();
                if (rsp_item.round_trip_delay !== want.round_trip_delay)
                    report_mismatch("round_trip_delay", want.round_trip_delay,
                                    rsp_item.round_trip_delay);
                if (rsp_item.clock_offset !== want.clock_offset)
                    report_mismatch("clock_offset", want.clock_offset, rsp_item.clock_offset);
                if (rsp_item.delay_dispersion !== want.delay_dispersion)
                    report_mismatch("delay_dispersion", want.delay_dispersion,
                                    rsp_item.delay_dispersion);
                if (rsp_item.root_disp_wide !== want.root_disp_wide)
                    report_mismatch("root_disp_wide", 64'(want.root_disp_wide),
                                    64'(rsp_item.root_disp_wide));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_ntp_delay_offset_dispersion: done, errors");
            $finish;
        end
    end

    function automatic void add_exchange(input logic [SLOT_W-1:0] slot,
                                         input logic [STAMP_W-1:0] t1,
                                         input logic [STAMP_W-1:0] t2,
                                         input logic [STAMP_W-1:0] t3,
                                         input logic [STAMP_W-1:0] t4,
                                         input logic [ROOT_DISP_IN_W-1:0] root);
        req_item_t it;
        it.slot = slot;
        it.client_send_time = t1;
        it.server_receive_time = t2;
        it.server_transmit_time = t3;
        it.client_receive_time = t4;
        it.server_root_disp = root;
        pending_exchanges.push_back(it);
    endfunction

    // Form 0 is a plausible exchange under the current epoch, 1 is pure noise, 2 is
    // a broken exchange with stamps near zero so that the epoch subtraction wraps.
    function automatic req_item_t make_exchange(input int form);
        req_item_t it;
        logic [STAMP_W-1:0] shift;
        logic [STAMP_W-1:0] rtt;
        logic [STAMP_W-1:0] hold;
        logic [STAMP_W-1:0] skew;
        logic [31:0] jitter;
        shift = {epoch_secs, 32'h0};
        it.slot = SLOT_W'($urandom_range(0, 7));
        it.server_root_disp = $urandom;
        if ($urandom_range(0, 7) == 0)
            it.server_root_disp = $urandom_range(0, 1) ? '0 : '1;
        if (form == 0)
        begin
            rtt = 64'($urandom) << $urandom_range(0, 3);
            if ($urandom_range(0, 15) == 0)
                rtt = 64'($urandom_range(0, 1));
            if ($urandom_range(0, 15) == 0)
                rtt = -rtt;
            hold = 64'($urandom_range(0, 32'h0FFF_FFFF));
            jitter = $urandom;
            skew = {{32{jitter[31]}}, jitter} <<< $urandom_range(0, 4);
            it.client_send_time = {$urandom, $urandom};
            it.server_receive_time = it.client_send_time + shift + skew;
            it.server_transmit_time = it.server_receive_time + hold;
            it.client_receive_time = it.client_send_time + hold + rtt;
        end
        else if (form == 1)
        begin
            it.client_send_time = {$urandom, $urandom};
            it.server_receive_time = {$urandom, $urandom};
            it.server_transmit_time = {$urandom, $urandom};
            it.client_receive_time = {$urandom, $urandom};
        end
        else
        begin
            it.client_send_time = 64'($urandom);
            it.server_receive_time = 64'($urandom);
            it.server_transmit_time = 64'($urandom);
            it.client_receive_time = 64'($urandom);
        end
        return it;
    endfunction

    // Waits until every item is sent and every result has come, then lets the pipeline settle.
    task automatic wait_drained;
        while (pending_exchanges.size() != 0 || req_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_epoch(input logic [SECONDS_W-1:0] secs);
        @(negedge clk);
        cfg_data <= secs;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        epoch_secs = secs;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int odds);
        int pick;
        idle_odds = odds;
        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            pending_exchanges.push_back(make_exchange(pick < 7 ? 0 : (pick < 9 ? 1 : 2)));
        end
        wait_drained();
    endtask

    initial
    begin
        logic [STAMP_W-1:0] es;
        req_item_t it;
        foreach (delay_win[i])
            delay_win[i] = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        es = {EPOCH_RESET, 32'h0};
        idle_odds = 4;
        add_exchange(3'd0, '0, '0, '0, '0, '0);
        add_exchange(3'd7, '1, '1, '1, '1, '1);
        add_exchange(3'd1, '0, es, es, '1, 32'h8000_0001);
        add_exchange(3'd2, '0, es + 64'h7FFF_FFFF_FFFF_FFFF, es, 64'h7FFF_FFFF_FFFF_FFFF,
                     32'h0000_FFFF);
        add_exchange(3'd3, '0, es + 64'h8000_0000_0000_0000, es, 64'h8000_0000_0000_0000,
                     32'hFFFF_0000);
        // Odd sums check that halving rounds towards minus infinity.
        add_exchange(3'd5, '0, es, es, 64'd3, 32'h1);
        add_exchange(3'd6, 64'd3, es, es, '0, 32'h2);
        // A zero delay is stored and then counts as an empty entry.
        add_exchange(3'd4, 64'h1000, es + 64'h5000, es + 64'h5000, 64'h1000, 32'h1);
        add_exchange(3'd2, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                     64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 32'h5555_AAAA);
        for (int s = 0; s < 8; s++)
        begin
            it = make_exchange(0);
            it.slot = SLOT_W'(s);
            pending_exchanges.push_back(it);
        end
        add_exchange(3'd7, '0, es + 64'd2, es + 64'd2, 64'd4, 32'hAAAA_5555);
        add_exchange(3'd7, 64'd9, es, es, 64'd9, '0);
        wait_drained();

        run_phase(170, 8);
        write_epoch('0);
        run_phase(170, 16);
        write_epoch('1);
        run_phase(170, 0);
        write_epoch($urandom);
        run_phase(170, 6);
        write_epoch(EPOCH_RESET);
        run_phase(170, 0);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb_ntp_delay_offset_dispersion: done, clean");
        else
            $display("tb_ntp_delay_offset_dispersion: done, errors");
        $finish;
    end

endmodule
